@@ hdl/edn_pkg.sv @@
package edn_pkg;

    localparam int WINDOW_DEPTH = 8;
    localparam int WC_W         = $clog2(WINDOW_DEPTH);
    localparam int LEN_W        = WC_W + 1;
    localparam int NUM_ENT      = 7;
    localparam int MAX_ENT_LEN  = 8;

    typedef logic [7:0] char_t;

    localparam char_t CHAR_AMP   = 8'h26;
    localparam char_t CHAR_MINUS = 8'h2d;
    localparam char_t CHAR_POINT = 8'h2e;
    localparam char_t CHAR_ZERO  = 8'h30;
    localparam char_t CHAR_NINE  = 8'h39;

    // entity names without the leading ampersand
    localparam char_t ENT_TAIL [NUM_ENT][MAX_ENT_LEN] = '{
        '{8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h67, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h6e, 8'h62, 8'h73, 8'h70, 8'h3b, 8'h00, 8'h00, 8'h00},
        '{8'h6e, 8'h65, 8'h77, 8'h6c, 8'h69, 8'h6e, 8'h65, 8'h3b},
        '{8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [LEN_W-1:0] ENT_LEN [NUM_ENT] = '{
        LEN_W'(4), LEN_W'(5), LEN_W'(3), LEN_W'(3), LEN_W'(5), LEN_W'(8), LEN_W'(5)
    };

    localparam char_t ENT_CHAR [NUM_ENT] = '{
        8'h26, 8'h27, 8'h3e, 8'h3c, 8'h20, 8'h0a, 8'h22
    };

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef struct packed {
        char_t out_byte;
        logic  final_result;
        logic  looks_numeric;
        logic  entity_replaced;
    } out_word_t;

endpackage

@@ hdl/edn_if.sv @@
interface edn_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface edn_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       final_result;
    logic       looks_numeric;
    logic       entity_replaced;

    modport source (output valid, output out_byte, output final_result,
                    output looks_numeric, output entity_replaced, input ready);
    modport sink   (input valid, input out_byte, input final_result,
                    input looks_numeric, input entity_replaced, output ready);
endinterface

@@ hdl/edn_cell.sv @@
module edn_cell
    import edn_pkg::*;
(
    input  logic      clk,
    input  cell_ctl_t ctl,
    input  char_t     new_byte,
    input  char_t     next_byte,
    output char_t     held_byte
);

    char_t data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            data_reg <= next_byte;
        end
        else if (ctl.load)
        begin
            data_reg <= new_byte;
        end
    end

    assign held_byte = data_reg;

endmodule

@@ hdl/entity_decode_number_check_unit.sv @@
// Entity decoder with decimal-number check. A string enters one byte per word and
// ends with a word whose end_of_string is set. Seven named entities (amp, apos, gt,
// lt, nbsp, newline, quot) come out as their single character; an ampersand whose
// following bytes stop forming an entity name comes out unchanged, followed by the
// held bytes and the breaking byte; a breaking ampersand opens a new entity instead.
// The last word of each string carries final_result with looks_numeric and
// entity_replaced. A byte that breaks a partial entity, or an end_of_string with
// an entity still open, starts a replay of the ampersand and the n held bytes (n
// from 0 to 7): the held bytes are replayed one per cycle while the output register
// is free, by shifting them out of the row of window cells. A new word is taken only
// while no replay runs and the output register is empty or is read in that cycle.
module entity_decode_number_check_unit
    import edn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    edn_in_if.sink    in_chan,
    edn_out_if.source out_chan
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    logic               state_reg,    state_next;
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_word_reg, out_word_next;
    logic               in_entity_reg, in_entity_next;
    logic [NUM_ENT-1:0] mask_reg,     mask_next;
    logic [WC_W-1:0]    wc_reg,       wc_next;
    logic               numeric_reg,  numeric_next;
    logic               point_reg,    point_next;
    logic               replaced_reg, replaced_next;
    logic               first_reg,    first_next;
    logic [WC_W-1:0]    rem_reg,      rem_next;
    logic               pend_valid_reg, pend_valid_next;
    out_word_t          pend_word_reg, pend_word_next;

    logic               slot_free;
    logic               accept;
    char_t              b;
    logic [NUM_ENT-1:0] match_vec;
    logic [NUM_ENT-1:0] hit_vec;
    logic               alive;
    char_t              hit_char;
    logic [LEN_W-1:0]   wc_ext;
    logic [LEN_W-1:0]   wc_inc;
    logic               do_append;
    logic               do_shift;
    cell_ctl_t          cell_ctl [WINDOW_DEPTH];
    char_t              held     [WINDOW_DEPTH];

    assign slot_free     = !out_valid_reg || out_chan.ready;
    assign in_chan.ready = (state_reg == ST_IDLE) && slot_free;
    assign accept        = in_chan.valid && in_chan.ready;
    assign b             = in_chan.in_byte;
    assign wc_ext        = {1'b0, wc_reg};
    assign wc_inc        = wc_ext + LEN_W'(1);

    // per-entity prefix tracking
    always_comb
    begin
        hit_char = '0;
        for (int e = 0; e < NUM_ENT; e++)
        begin
            match_vec[e] = mask_reg[e] && (ENT_TAIL[e][wc_reg] == b) && (wc_ext < ENT_LEN[e]);
            hit_vec[e]   = match_vec[e] && (wc_inc == ENT_LEN[e]);
            if (hit_vec[e])
            begin
                hit_char = hit_char | ENT_CHAR[e];
            end
        end
        alive = |(match_vec & ~hit_vec);
    end

    always_comb
    begin
        state_next      = state_reg;
        in_entity_next  = in_entity_reg;
        mask_next       = mask_reg;
        wc_next         = wc_reg;
        numeric_next    = numeric_reg;
        point_next      = point_reg;
        replaced_next   = replaced_reg;
        first_next      = first_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        pend_word_next  = pend_word_reg;
        out_word_next   = out_word_reg;
        out_valid_next  = out_valid_reg && !out_chan.ready;
        do_append       = 1'b0;
        do_shift        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_chan.end_of_string)
                    begin
                        pend_word_next = '{out_byte: '0, final_result: 1'b1,
                                           looks_numeric: numeric_reg,
                                           entity_replaced: replaced_reg};
                        in_entity_next = 1'b0;
                        wc_next        = '0;
                        numeric_next   = 1'b1;
                        point_next     = 1'b0;
                        replaced_next  = 1'b0;
                        first_next     = 1'b1;
                        out_valid_next = 1'b1;
                        if (in_entity_reg)
                        begin
                            out_word_next   = '{out_byte: CHAR_AMP, default: 1'b0};
                            pend_valid_next = 1'b1;
                            rem_next        = wc_reg;
                            state_next      = ST_FLUSH;
                        end
                        else
                        begin
                            out_word_next = pend_word_next;
                        end
                    end
                    else
                    begin
                        first_next = 1'b0;
                        if (!(first_reg && b == CHAR_MINUS))
                        begin
                            if (b == CHAR_POINT)
                            begin
                                if (point_reg)
                                begin
                                    numeric_next = 1'b0;
                                end
                                point_next = 1'b1;
                            end
                            else if (b < CHAR_ZERO || b > CHAR_NINE)
                            begin
                                numeric_next = 1'b0;
                            end
                        end

                        if (!in_entity_reg)
                        begin
                            if (b == CHAR_AMP)
                            begin
                                in_entity_next = 1'b1;
                                mask_next      = '1;
                                wc_next        = '0;
                            end
                            else
                            begin
                                out_valid_next = 1'b1;
                                out_word_next  = '{out_byte: b, default: 1'b0};
                            end
                        end
                        else if (|hit_vec)
                        begin
                            out_valid_next = 1'b1;
                            out_word_next  = '{out_byte: hit_char, default: 1'b0};
                            replaced_next  = 1'b1;
                            in_entity_next = 1'b0;
                            wc_next        = '0;
                        end
                        else if (alive)
                        begin
                            do_append = 1'b1;
                            wc_next   = wc_reg + WC_W'(1);
                            mask_next = match_vec;
                        end
                        else
                        begin
                            // broken entity: replay ampersand and held bytes
                            out_valid_next = 1'b1;
                            out_word_next  = '{out_byte: CHAR_AMP, default: 1'b0};
                            rem_next       = wc_reg;
                            state_next     = ST_FLUSH;
                            wc_next        = '0;
                            if (b == CHAR_AMP)
                            begin
                                in_entity_next  = 1'b1;
                                mask_next       = '1;
                                pend_valid_next = 1'b0;
                            end
                            else
                            begin
                                in_entity_next  = 1'b0;
                                pend_valid_next = 1'b1;
                                pend_word_next  = '{out_byte: b, default: 1'b0};
                            end
                        end
                    end
                end
            end
            ST_FLUSH:
            begin
                if (slot_free)
                begin
                    if (rem_reg != '0)
                    begin
                        out_valid_next = 1'b1;
                        out_word_next  = '{out_byte: held[0], default: 1'b0};
                        do_shift       = 1'b1;
                        rem_next       = rem_reg - WC_W'(1);
                    end
                    else
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_word_next  = pend_word_reg;
                        end
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            in_entity_reg  <= 1'b0;
            mask_reg       <= '0;
            wc_reg         <= '0;
            numeric_reg    <= 1'b1;
            point_reg      <= 1'b0;
            replaced_reg   <= 1'b0;
            first_reg      <= 1'b1;
            rem_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            in_entity_reg  <= in_entity_next;
            mask_reg       <= mask_next;
            wc_reg         <= wc_next;
            numeric_reg    <= numeric_next;
            point_reg      <= point_next;
            replaced_reg   <= replaced_next;
            first_reg      <= first_next;
            rem_reg        <= rem_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg  <= out_word_next;
        pend_word_reg <= pend_word_next;
    end

    // lookahead window as a row of shifting cells
    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        assign cell_ctl[i] = '{load: do_append && (wc_reg == WC_W'(i)), shift: do_shift};

        if (i == WINDOW_DEPTH - 1)
        begin : g_last
            edn_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .new_byte  (b),
                .next_byte (8'h00),
                .held_byte (held[i])
            );
        end
        else
        begin : g_mid
            edn_cell u_cell (
                .clk       (clk),
                .ctl       (cell_ctl[i]),
                .new_byte  (b),
                .next_byte (held[i+1]),
                .held_byte (held[i])
            );
        end
    end

    assign out_chan.valid           = out_valid_reg;
    assign out_chan.out_byte        = out_word_reg.out_byte;
    assign out_chan.final_result    = out_word_reg.final_result;
    assign out_chan.looks_numeric   = out_word_reg.looks_numeric;
    assign out_chan.entity_replaced = out_word_reg.entity_replaced;

`ifndef ASSERT_OFF
    a_entity_mask: assert property (@(posedge clk) disable iff (!rst_n)
        in_entity_reg |-> mask_reg != '0)
        else $error("open entity with no candidate left");

    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_entity_reg |-> wc_reg == '0)
        else $error("window count nonzero outside entity");

    a_rem_flush: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != '0 |-> state_reg == ST_FLUSH)
        else $error("replay count left outside flush");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && in_entity_reg |-> $onehot0(hit_vec))
        else $error("more than one entity matched");

    a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.final_result |-> out_word_reg.out_byte == '0)
        else $error("final word carries a byte");
`endif

endmodule

@@ bench/entity_decode_number_check_unit_test.sv @@
`timescale 1ns / 100ps

module entity_decode_number_check_unit_test;
    import edn_pkg::*;

    logic clk = 1'b0;
    logic rst_n;

    edn_in_if  in_chan ();
    edn_out_if out_chan ();

    entity_decode_number_check_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan)
    );

    always #4 clk = ~clk;

    // decoder state as seen from outside
    char_t held_bytes [WINDOW_DEPTH];
    int    held_count;
    logic  open_entity;
    logic  numeric_ok;
    logic  point_seen;
    logic  replaced_any;
    logic  first_pos;

    out_word_t decoded_words [$];

    int  mismatches      = 0;
    int  words_checked   = 0;
    int  items_sent      = 0;
    int  strings_sent    = 0;
    int  entity_hits     = 0;
    int  numeric_strings = 0;
    int  hold_off_cycles = 0;
    bit  sender_idles    = 1'b1;
    bit  receiver_idles  = 1'b1;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void clear_string();
        held_count   = 0;
        open_entity  = 1'b0;
        numeric_ok   = 1'b1;
        point_seen   = 1'b0;
        replaced_any = 1'b0;
        first_pos    = 1'b1;
    endfunction

    function automatic void emit(char_t b, logic fin, logic num, logic rep);
        out_word_t w;
        w.out_byte        = b;
        w.final_result    = fin;
        w.looks_numeric   = num;
        w.entity_replaced = rep;
        decoded_words.push_back(w);
    endfunction

    function automatic void replay_window(int n);
        emit(CHAR_AMP, 1'b0, 1'b0, 1'b0);
        for (int k = 0; k < n && k < WINDOW_DEPTH; k++)
            emit(held_bytes[k], 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void pass_or_open(char_t b);
        if (b == CHAR_AMP)
        begin
            open_entity = 1'b1;
            held_count  = 0;
        end
        else
            emit(b, 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void decode_byte(char_t b, logic eos);
        bit alive;
        bit same;
        int hit;
        int held;
        if (eos)
        begin
            if (open_entity)
                replay_window(held_count);
            emit(8'h00, 1'b1, numeric_ok, replaced_any);
            if (numeric_ok)
                numeric_strings++;
            strings_sent++;
            clear_string();
            return;
        end
        if (!(first_pos && b == CHAR_MINUS))
        begin
            if (b == CHAR_POINT)
            begin
                if (point_seen)
                    numeric_ok = 1'b0;
                point_seen = 1'b1;
            end
            else if (b < CHAR_ZERO || b > CHAR_NINE)
                numeric_ok = 1'b0;
        end
        first_pos = 1'b0;
        if (!open_entity)
        begin
            pass_or_open(b);
            return;
        end
        alive = 1'b0;
        hit   = -1;
        if (held_count < WINDOW_DEPTH)
        begin
            held_bytes[held_count] = b;
            held_count++;
            for (int e = 0; e < NUM_ENT; e++)
            begin
                if (held_count <= int'(ENT_LEN[e]))
                begin
                    same = 1'b1;
                    for (int k = 0; k < held_count; k++)
                        if (held_bytes[k] != ENT_TAIL[e][k])
                            same = 1'b0;
                    if (same)
                    begin
                        if (held_count == int'(ENT_LEN[e]))
                            hit = e;
                        else
                            alive = 1'b1;
                    end
                end
            end
        end
        if (hit >= 0)
        begin
            emit(ENT_CHAR[hit], 1'b0, 1'b0, 1'b0);
            entity_hits++;
            replaced_any = 1'b1;
            open_entity  = 1'b0;
            held_count   = 0;
        end
        else if (!alive)
        begin
            held = held_count > 0 ? held_count - 1 : 0;
            replay_window(held);
            open_entity = 1'b0;
            held_count  = 0;
            pass_or_open(b);
        end
    endfunction

    task automatic send_word(input char_t b, input logic eos);
        int gap;
        in_chan.valid         <= 1'b1;
        in_chan.in_byte       <= b;
        in_chan.end_of_string <= eos;
        @(posedge clk);
        while (!in_chan.ready)
            @(posedge clk);
        decode_byte(b, eos);
        items_sent++;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(char_t'(s[i]), 1'b0);
    endtask

    task automatic end_string();
        send_word(char_t'($urandom), 1'b1);
    endtask

    task automatic send_entity(input int e, input int upto);
        send_word(CHAR_AMP, 1'b0);
        for (int k = 0; k < upto; k++)
            send_word(ENT_TAIL[e][k], 1'b0);
    endtask

    function automatic char_t numeric_char();
        int r;
        r = $urandom_range(0, 11);
        if (r < 10)
            return char_t'(CHAR_ZERO + r);
        return r == 10 ? CHAR_POINT : CHAR_MINUS;
    endfunction

    task automatic wait_drained();
        in_chan.valid <= 1'b0;
        while (decoded_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_string();
        int    len;
        int    point_at;
        int    kind;
        int    e;
        char_t brk;
        if ($urandom_range(0, 4) == 0)
        begin
            // well-formed number
            if ($urandom_range(0, 1))
                send_word(CHAR_MINUS, 1'b0);
            len      = $urandom_range(1, 6);
            point_at = $urandom_range(0, len);
            for (int i = 0; i < len; i++)
                send_word(i == point_at ? CHAR_POINT : char_t'(CHAR_ZERO + $urandom_range(0, 9)),
                          1'b0);
        end
        else
        begin
            repeat ($urandom_range(0, 6))
            begin
                kind = $urandom_range(0, 99);
                e    = $urandom_range(0, NUM_ENT - 1);
                if (kind < 35)
                    send_entity(e, ENT_LEN[e]);
                else if (kind < 55)
                begin
                    send_entity(e, $urandom_range(0, ENT_LEN[e] - 1));
                    brk = ($urandom_range(0, 3) == 0) ? CHAR_AMP : char_t'($urandom);
                    send_word(brk, 1'b0);
                end
                else if (kind < 62)
                    send_entity(e, $urandom_range(0, ENT_LEN[e] - 1));
                else if (kind < 82)
                    send_word(numeric_char(), 1'b0);
                else
                    send_word(char_t'($urandom), 1'b0);
            end
        end
        end_string();
    endtask

    task automatic test_number_forms();
        end_string();
        send_text("-");
        end_string();
        send_text("-9.0");
        end_string();
        send_text("1..");
        end_string();
        send_text("0-");
        end_string();
        wait_drained();
    endtask

    task automatic test_odd_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'hff, 1'b0);
        end_string();
        wait_drained();
    endtask

    task automatic test_entity_edges();
        // replaced, broken by a new ampersand, then left open at the end
        send_text("&lt;&a&quo");
        end_string();
        wait_drained();
    endtask

    task automatic test_random_strings();
        int start;
        start = items_sent;
        while (items_sent - start < 130)
        begin
            sender_idles   = ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            send_random_string();
        end
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
        wait_drained();
    endtask

    task automatic test_back_to_back();
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        repeat (5) send_random_string();
        wait_drained();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    task automatic test_output_stall();
        sender_idles    = 1'b0;
        hold_off_cycles = 120;
        repeat (4) send_random_string();
        wait_drained();
        sender_idles = 1'b1;
    endtask

    // receiver
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                stall_left      = hold_off_cycles;
                hold_off_cycles = 0;
            end
            if (stall_left > 0)
            begin
                out_chan.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_chan.ready <= 1'b1;
                if (receiver_idles)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_chan.valid && out_chan.ready)
        begin
            words_checked++;
            if (decoded_words.size() == 0)
            begin
                $error("unexpected word: out_byte %02h final_result %0b",
                       out_chan.out_byte, out_chan.final_result);
                mismatches++;
            end
            else
            begin
                want = decoded_words.pop_front();
                if (out_chan.out_byte !== want.out_byte)
                begin
                    $error("out_byte: expected %02h, got %02h",
                           want.out_byte, out_chan.out_byte);
                    mismatches++;
                end
                if (out_chan.final_result !== want.final_result)
                begin
                    $error("final_result: expected %0b, got %0b",
                           want.final_result, out_chan.final_result);
                    mismatches++;
                end
                if (out_chan.looks_numeric !== want.looks_numeric)
                begin
                    $error("looks_numeric: expected %0b, got %0b",
                           want.looks_numeric, out_chan.looks_numeric);
                    mismatches++;
                end
                if (out_chan.entity_replaced !== want.entity_replaced)
                begin
                    $error("entity_replaced: expected %0b, got %0b",
                           want.entity_replaced, out_chan.entity_replaced);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        clear_string();
        rst_n                 <= 1'b0;
        in_chan.valid         <= 1'b0;
        in_chan.in_byte       <= 8'h00;
        in_chan.end_of_string <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_number_forms();
        test_odd_bytes();
        test_entity_edges();
        test_back_to_back();
        test_output_stall();
        test_random_strings();

        wait_drained();
        repeat (20) @(posedge clk);
        $display("run covered %0d strings, %0d input words, %0d output words checked",
                 strings_sent, items_sent, words_checked);
        $display("entities decoded: %0d, strings judged numeric: %0d",
                 entity_hits, numeric_strings);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
hdl/edn_pkg.sv
hdl/edn_if.sv
hdl/edn_cell.sv
hdl/entity_decode_number_check_unit.sv
bench/entity_decode_number_check_unit_test.sv
